@@ src/tccs_pkg.sv @@
// tccs_pkg: shared constants, transaction types and sequencer states for the
// text console cursor and scroll unit
// no dependencies
`default_nettype none

package tccs_pkg;

    localparam int TCCS_COLUMNS = 80;
    localparam int TCCS_ROWS    = 25;

    localparam int OPCODE_W = 2;
    localparam int CHAR_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int ROW_W    = 5;
    localparam int COL_W    = 7;
    localparam int POS_W    = 11;
    localparam int CELL_W   = 16;
    localparam int ATTR_W   = 8;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;

    localparam logic [OPCODE_W-1:0] OP_PUT  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_BACK = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_INIT = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_READ = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [CHAR_W-1:0]   char_code;
        logic [INDEX_W-1:0]  cell_index;
    } in_t;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic [POS_W-1:0]  cursor_position;
        logic [CELL_W-1:0] read_data;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_FILL,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

@@ src/tccs_screen_ram.sv @@
// tccs_screen_ram: screen cell memory, one write and one registered read port
// depends on tccs_pkg
`default_nettype none

module tccs_screen_ram #(
    parameter int DEPTH = tccs_pkg::TCCS_ROWS * tccs_pkg::TCCS_COLUMNS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [AW-1:0]               waddr,
    input  wire logic [tccs_pkg::CELL_W-1:0] wdata,
    input  wire logic                        re,
    input  wire logic [AW-1:0]               raddr,
    output logic      [tccs_pkg::CELL_W-1:0] rdata
);
    import tccs_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ src/tccs_seq.sv @@
// tccs_seq: sequencer with cursor registers and the shared scan counter that
// walks the screen for scroll and clear
// depends on tccs_pkg; drives tccs_screen_ram
`default_nettype none

module tccs_seq #(
    parameter int COLUMNS = tccs_pkg::TCCS_COLUMNS,
    parameter int ROWS    = tccs_pkg::TCCS_ROWS,
    parameter int AW      = $clog2(ROWS * COLUMNS)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire tccs_pkg::in_t               in_item,
    input  wire logic [tccs_pkg::ATTR_W-1:0] attr,
    input  wire logic                        take,
    output logic                             idle,
    output logic                             done,
    output tccs_pkg::out_t                   result,
    output logic                             ram_we,
    output logic      [AW-1:0]               ram_waddr,
    output logic      [tccs_pkg::CELL_W-1:0] ram_wdata,
    output logic                             ram_re,
    output logic      [AW-1:0]               ram_raddr,
    input  wire logic [tccs_pkg::CELL_W-1:0] ram_rdata
);
    import tccs_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
    localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
    localparam logic [AW-1:0] COPY_LAST = AW'((ROWS - 1) * COLUMNS - 1);
    localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);

    state_t state_reg, state_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] base_reg, base_next;
    logic [AW-1:0] scan_reg, scan_next;

    logic [OPCODE_W-1:0] op_reg;
    logic [CHAR_W-1:0]   ch_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic                read_ok_reg;

    logic is_newline;
    logic line_end;
    logic needs_scroll;
    logic back_ok;
    logic read_in_range;

    assign is_newline    = (ch_reg == NEWLINE_CODE);
    assign line_end      = is_newline || (col_reg == COL_LAST);
    assign needs_scroll  = (op_reg == OP_PUT) && line_end && (row_reg == ROW_LAST);
    assign back_ok       = (row_reg != '0) || (col_reg != '0);
    assign read_in_range = (32'(idx_reg) < 32'(CELLS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            pos_reg   <= '0;
            base_reg  <= '0;
            scan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            pos_reg   <= pos_next;
            base_reg  <= base_next;
            scan_reg  <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg  <= in_item.opcode;
            ch_reg  <= in_item.char_code;
            idx_reg <= in_item.cell_index;
        end
        if (state_reg == ST_EXEC)
        begin
            read_ok_reg <= (op_reg == OP_READ) && read_in_range;
        end
    end

    // cursor and scan counter
    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        pos_next  = pos_reg;
        base_next = base_reg;
        scan_next = scan_reg;
        case (state_reg)
            ST_EXEC:
            begin
                scan_next = '0;
                case (op_reg)
                    OP_PUT:
                    begin
                        if (line_end)
                        begin
                            col_next = '0;
                            if (row_reg == ROW_LAST)
                            begin
                                pos_next = base_reg;
                            end
                            else
                            begin
                                row_next  = row_reg + 1'b1;
                                base_next = base_reg + COLS_A;
                                pos_next  = base_reg + COLS_A;
                            end
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                    OP_BACK:
                    begin
                        if (back_ok)
                        begin
                            pos_next = pos_reg - 1'b1;
                            if (col_reg != '0)
                            begin
                                col_next = col_reg - 1'b1;
                            end
                            else
                            begin
                                row_next  = row_reg - 1'b1;
                                col_next  = COL_LAST;
                                base_next = base_reg - COLS_A;
                            end
                        end
                    end
                    OP_INIT:
                    begin
                        row_next  = '0;
                        col_next  = '0;
                        pos_next  = '0;
                        base_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SCROLL_WR, ST_FILL:
            begin
                scan_next = scan_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (needs_scroll)
                begin
                    state_next = ST_SCROLL_RD;
                end
                else if (op_reg == OP_INIT)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCROLL_RD:
            begin
                state_next = ST_SCROLL_WR;
            end
            ST_SCROLL_WR:
            begin
                state_next = (scan_reg == COPY_LAST) ? ST_FILL : ST_SCROLL_RD;
            end
            ST_FILL:
            begin
                if (scan_reg == CELL_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory port and status outputs
    always_comb
    begin
        idle      = (state_reg == ST_IDLE);
        done      = (state_reg == ST_FINISH);
        ram_we    = 1'b0;
        ram_waddr = scan_reg;
        ram_wdata = {attr, BLANK_CODE};
        ram_re    = 1'b0;
        ram_raddr = AW'(idx_reg);
        case (state_reg)
            ST_EXEC:
            begin
                case (op_reg)
                    OP_PUT:
                    begin
                        ram_we    = !is_newline;
                        ram_waddr = pos_reg;
                        ram_wdata = {attr, ch_reg};
                    end
                    OP_BACK:
                    begin
                        ram_we    = back_ok;
                        ram_waddr = pos_reg - 1'b1;
                    end
                    OP_READ:
                    begin
                        ram_re = read_in_range;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SCROLL_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = scan_reg + COLS_A;
            end
            ST_SCROLL_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            ST_FILL:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign result.cursor_row      = ROW_W'(32'(row_reg));
    assign result.cursor_col      = COL_W'(32'(col_reg));
    assign result.cursor_position = POS_W'(32'(pos_reg));
    assign result.read_data       = read_ok_reg ? ram_rdata : '0;

endmodule

`default_nettype wire

@@ src/text_console_cursor_scroll_unit.sv @@
// text_console_cursor_scroll_unit: put/backspace/clear/read console engine
// sequence: put, newline, backspace and read pass from idle through execute and
// finish into the output register; a scroll copies each cell of rows 1..ROWS-1
// up one row by a read and a write, then blanks the bottom row; initialize
// blanks every cell, one cell per cycle; finish waits until the output register
// can take the result, and the next transaction is taken once the sequencer is idle
// reset: cursor at the origin, attribute 7, screen undefined until initialize
`default_nettype none

module text_console_cursor_scroll_unit #(
    parameter int COLUMNS = tccs_pkg::TCCS_COLUMNS,
    parameter int ROWS    = tccs_pkg::TCCS_ROWS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire tccs_pkg::in_t               in_data,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output tccs_pkg::out_t                   out_data,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [tccs_pkg::ATTR_W-1:0] cfg_data
);
    import tccs_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    logic [ATTR_W-1:0] attr_reg;
    logic              out_valid_reg, out_valid_next;
    out_t              out_data_reg;

    logic              idle;
    logic              done;
    logic              take;
    logic              start;
    out_t              result;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    assign in_stall  = !idle;
    assign start     = in_valid && idle;
    assign cfg_ready = 1'b1;
    assign take      = !out_valid_reg || !out_stall;

    assign out_valid_next = (done && take) || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done && take)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    tccs_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .in_item   (in_data),
        .attr      (attr_reg),
        .take      (take),
        .idle      (idle),
        .done      (done),
        .result    (result),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    tccs_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("accepted transaction did not make the sequencer busy");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (done && take) |=> out_valid)
        else $error("finished transaction not presented on the output");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (32'(ram_waddr) < 32'(CELLS)))
        else $error("screen write address beyond the last cell");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (32'(ram_raddr) < 32'(CELLS)))
        else $error("screen read address beyond the last cell");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// testbench: self-checking bench for text_console_cursor_scroll_unit
// drives put/backspace/clear/read transactions and checks cursor and cell data
// depends on tccs_pkg and text_console_cursor_scroll_unit
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tccs_pkg::*;

    localparam int CELLS = TCCS_ROWS * TCCS_COLUMNS;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int PHASE_ITEMS = 210;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ATTR_W-1:0] cfg_data = '0;

    in_t command_queue[$];
    out_t expected_status[$];
    out_t want;

    logic [CELL_W-1:0] screen_shadow [CELLS];
    int cur_row = 0;
    int cur_col = 0;
    logic [ATTR_W-1:0] attr = ATTR_RESET;

    int errors = 0;
    int cycle_count = 0;
    logic calm = 1'b0;
    logic squeeze_req = 1'b0;
    logic squeeze_done = 1'b0;
    int hold_left = 0;

    text_console_cursor_scroll_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void next_row();
        int k;
        cur_row++;
        if (cur_row >= TCCS_ROWS)
        begin
            for (k = 0; k < (TCCS_ROWS - 1) * TCCS_COLUMNS; k++)
                screen_shadow[k] = screen_shadow[k + TCCS_COLUMNS];
            for (k = 0; k < TCCS_COLUMNS; k++)
                screen_shadow[(TCCS_ROWS - 1) * TCCS_COLUMNS + k] = {attr, BLANK_CODE};
            cur_row = TCCS_ROWS - 1;
        end
    endfunction

    function automatic out_t advance_console(input in_t cmd);
        out_t res;
        logic [CELL_W-1:0] data;
        int k;
        data = '0;
        case (cmd.opcode)
            OP_PUT:
            begin
                if (cmd.char_code == NEWLINE_CODE)
                begin
                    cur_col = 0;
                    next_row();
                end
                else
                begin
                    screen_shadow[cur_row * TCCS_COLUMNS + cur_col] = {attr, cmd.char_code};
                    cur_col++;
                    if (cur_col >= TCCS_COLUMNS)
                    begin
                        cur_col = 0;
                        next_row();
                    end
                end
            end
            OP_BACK:
            begin
                if (cur_row != 0 || cur_col != 0)
                begin
                    if (cur_col > 0)
                        cur_col--;
                    else
                    begin
                        cur_row--;
                        cur_col = TCCS_COLUMNS - 1;
                    end
                    screen_shadow[cur_row * TCCS_COLUMNS + cur_col] = {attr, BLANK_CODE};
                end
            end
            OP_INIT:
            begin
                cur_row = 0;
                cur_col = 0;
                for (k = 0; k < CELLS; k++)
                    screen_shadow[k] = {attr, BLANK_CODE};
            end
            default:
            begin
                if (cmd.cell_index < CELLS)
                    data = screen_shadow[cmd.cell_index];
            end
        endcase
        res.cursor_row = cur_row[ROW_W-1:0];
        res.cursor_col = cur_col[COL_W-1:0];
        res.cursor_position = POS_W'(cur_row * TCCS_COLUMNS + cur_col);
        res.read_data = data;
        return res;
    endfunction

    function automatic in_t make_cmd(input logic [OPCODE_W-1:0] op,
                                     input logic [CHAR_W-1:0] ch,
                                     input logic [INDEX_W-1:0] idx);
        in_t cmd;
        cmd.opcode = op;
        cmd.char_code = ch;
        cmd.cell_index = idx;
        return cmd;
    endfunction

    // at least half the reads land in the bottom two rows where text collects
    function automatic logic [INDEX_W-1:0] pick_cell();
        if ($urandom_range(0, 1) == 0)
            return INDEX_W'($urandom_range(0, 2047));
        return INDEX_W'($urandom_range(CELLS - 2 * TCCS_COLUMNS, CELLS - 1));
    endfunction

    task automatic plan_traffic(input int count);
        int made;
        int kind;
        int len;
        int k;
        made = 0;
        while (made < count)
        begin
            kind = $urandom_range(0, 99);
            len = $urandom_range(1, 4);
            if (kind < 50)
            begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(70, 90)
                                                   : $urandom_range(0, 12);
                for (k = 0; k < len; k++)
                    command_queue.push_back(make_cmd(OP_PUT, CHAR_W'($urandom_range(0, 255)),
                                                     INDEX_W'($urandom_range(0, 2047))));
                if ($urandom_range(0, 4) != 0)
                begin
                    command_queue.push_back(make_cmd(OP_PUT, NEWLINE_CODE,
                                                     INDEX_W'($urandom_range(0, 2047))));
                    len++;
                end
            end
            else if (kind < 72)
            begin
                for (k = 0; k < len; k++)
                    command_queue.push_back(make_cmd(OP_READ, CHAR_W'($urandom_range(0, 255)),
                                                     pick_cell()));
            end
            else if (kind < 88)
            begin
                len = $urandom_range(1, 3);
                for (k = 0; k < len; k++)
                    command_queue.push_back(make_cmd(OP_BACK, CHAR_W'($urandom_range(0, 255)),
                                                     INDEX_W'($urandom_range(0, 2047))));
            end
            else if (kind < 94)
            begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++)
                    command_queue.push_back(make_cmd(OP_PUT, NEWLINE_CODE,
                                                     INDEX_W'($urandom_range(0, 2047))));
            end
            else if (kind < 99)
            begin
                len = $urandom_range(1, 3);
                for (k = 0; k < len; k++)
                    command_queue.push_back(make_cmd(OPCODE_W'($urandom_range(0, 3)),
                                                     CHAR_W'($urandom_range(0, 255)),
                                                     pick_cell()));
            end
            else
            begin
                len = 1;
                command_queue.push_back(make_cmd(OP_INIT, CHAR_W'($urandom_range(0, 255)),
                                                 INDEX_W'($urandom_range(0, 2047))));
            end
            made += len;
        end
    endtask

    task automatic drain();
        while (command_queue.size() != 0 || in_valid || expected_status.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        attr = value;
        @(negedge clk);
    endtask

    task automatic compare_field(input string name, input int unsigned exp_val,
                                 input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
            errors++;
        end
    endtask

    // driver: holds a transaction until accepted, then offers the next
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            expected_status.push_back(advance_console(in_data));
        if (!(in_valid && in_stall))
        begin
            if (rst_n && command_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 28))
            begin
                in_data <= command_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge clk)
    begin
        if (squeeze_req && !squeeze_done)
        begin
            hold_left <= 400;
            squeeze_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_status.size() == 0)
            begin
                $error("result with no transaction pending: row %0d col %0d",
                       out_data.cursor_row, out_data.cursor_col);
                errors++;
            end
            else
            begin
                want = expected_status.pop_front();
                compare_field("cursor_row", want.cursor_row, out_data.cursor_row);
                compare_field("cursor_col", want.cursor_col, out_data.cursor_col);
                compare_field("cursor_position", want.cursor_position,
                              out_data.cursor_position);
                compare_field("read_data", want.read_data, out_data.read_data);
            end
        end
        if (hold_left > 0)
            out_stall <= 1'b1;
        else
            out_stall <= !calm && ($urandom_range(0, 99) < 28);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        logic [ATTR_W-1:0] phase_attr [4];
        int p;
        for (p = 0; p < CELLS; p++)
            screen_shadow[p] = '0;
        phase_attr[0] = 8'h00;
        phase_attr[1] = ATTR_W'($urandom_range(1, 254));
        phase_attr[2] = ATTR_W'($urandom_range(1, 254));
        phase_attr[3] = ATTR_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_attribute(8'hFF);
        // backspace at the origin and out-of-range reads before any clear
        command_queue.push_back(make_cmd(OP_BACK, 8'h00, 11'd0));
        command_queue.push_back(make_cmd(OP_READ, 8'hFF, 11'd2047));
        command_queue.push_back(make_cmd(OP_READ, 8'h00, 11'(CELLS)));
        command_queue.push_back(make_cmd(OP_INIT, 8'h5A, 11'h7FF));
        command_queue.push_back(make_cmd(OP_READ, 8'h00, 11'd0));
        command_queue.push_back(make_cmd(OP_PUT, 8'h41, 11'd0));
        command_queue.push_back(make_cmd(OP_PUT, 8'hFF, 11'h7FF));
        command_queue.push_back(make_cmd(OP_PUT, 8'h00, 11'd0));
        command_queue.push_back(make_cmd(OP_READ, 8'h00, 11'd0));
        command_queue.push_back(make_cmd(OP_READ, 8'h00, 11'd1));
        command_queue.push_back(make_cmd(OP_READ, 8'h00, 11'd2));
        command_queue.push_back(make_cmd(OP_BACK, 8'hFF, 11'd0));
        command_queue.push_back(make_cmd(OP_READ, 8'h00, 11'd2));
        command_queue.push_back(make_cmd(OP_PUT, NEWLINE_CODE, 11'd0));
        // backspace across the row boundary, then wrap at the line end
        command_queue.push_back(make_cmd(OP_BACK, 8'h00, 11'd0));
        command_queue.push_back(make_cmd(OP_READ, 8'h00, 11'(TCCS_COLUMNS - 1)));
        command_queue.push_back(make_cmd(OP_PUT, 8'h7E, 11'd0));
        command_queue.push_back(make_cmd(OP_READ, 8'h00, 11'(TCCS_COLUMNS - 1)));
        command_queue.push_back(make_cmd(OP_READ, 8'h00, 11'(CELLS - 1)));
        drain();

        for (p = 0; p < 4; p++)
        begin
            write_attribute(phase_attr[p]);
            calm = (p == 1);
            plan_traffic(PHASE_ITEMS);
            if (p == 2)
                squeeze_req = 1'b1;
            drain();
        end

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
